[src/arxkbc_pkg.sv]
package arxkbc_pkg;

   localparam int DataWidth = 8;
   localparam int WordWidth = 32;
   localparam int KeyWidth = 56;
   localparam int ModeWidth = 2;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth = KeyWidth;

   localparam int WarmRounds = 8;
   localparam int WarmCountWidth = $clog2(WarmRounds + 1);

   localparam logic [7:0] SeedPad = 8'h5A;

   localparam int RotFirst = 13;
   localparam int RotSecond = 16;
   localparam int RotThird = 7;

   // register indexes on the csr port
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CIPHER_MODE = 1'b0,
      CSR_KEY_BITS    = 1'b1
   } csr_index_type;

   typedef enum logic [ModeWidth-1:0] {
      MODE_NONE        = 2'd0,
      MODE_SINGLE_XOR  = 2'd1,
      MODE_ARX_STREAM  = 2'd2,
      MODE_UNSUPPORTED = 2'd3
   } cipher_mode_type;

   typedef struct packed {
      logic [WordWidth-1:0] word_a;
      logic [WordWidth-1:0] word_b;
   } mix_pair_type;

   function automatic logic [WordWidth-1:0] rot_left(
      input logic [WordWidth-1:0] value,
      input int unsigned          shift
   );
      rot_left = (value << shift) | (value >> (WordWidth - shift));
   endfunction

   // one add-rotate-xor round: two adds in series, rotates are wiring
   function automatic mix_pair_type arx_round(input mix_pair_type pair);
      logic [WordWidth-1:0] a_sum;
      logic [WordWidth-1:0] b_mix;
      logic [WordWidth-1:0] a_rot;
      mix_pair_type         result;
      a_sum = pair.word_a + pair.word_b;
      b_mix = rot_left(pair.word_b, RotFirst) ^ a_sum;
      a_rot = rot_left(a_sum, RotSecond);
      result.word_b = b_mix + a_rot;
      result.word_a = rot_left(a_rot, RotThird);
      arx_round = result;
   endfunction

   // unwarmed seed taken straight from the key
   function automatic mix_pair_type seed_from_key(input logic [KeyWidth-1:0] key);
      mix_pair_type result;
      result.word_a = key[WordWidth-1:0];
      result.word_b = {SeedPad, key[KeyWidth-1:WordWidth]};
      seed_from_key = result;
   endfunction

endpackage

[src/arxkbc_req_if.sv]
interface arxkbc_req_if;
   import arxkbc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] data_in;
   logic                 last_of_buffer;

   modport source (output valid, output data_in, output last_of_buffer, input ready);
   modport sink (input valid, input data_in, input last_of_buffer, output ready);

endinterface

[src/arxkbc_rsp_if.sv]
interface arxkbc_rsp_if;
   import arxkbc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] data_out;
   logic                 mode_error;

   modport source (output valid, output data_out, output mode_error, input ready);
   modport sink (input valid, input data_out, input mode_error, output ready);

endinterface

[src/arx_keystream_byte_cipher_unit.sv]
// Byte-stream cipher, one request byte in and one response byte out per clock. Mode 0 passes
// the byte, mode 1 xors it with key byte 0, mode 2 xors it with the low byte of word b of a
// two-word add-rotate-xor generator that steps once per mode-2 byte, and mode 3 passes the
// byte and raises mode_error. Each buffer (closed by last_of_buffer) restarts the generator
// from a warmed seed: the key with 0x5A on top, run through eight rounds. That seed is built
// in the background by a one-round-per-clock warm-up unit, so after reset and after every key
// write req_ready stays low until the count runs out; otherwise a request is taken every clock
// and its response is in an output register the cycle after; req_ready follows rsp_ready so a
// stalled response holds the input side. Config must be written only while idle, which is not
// enforced; the mode is sampled per request; a new key seeds mode 2 at the next buffer start.
module arx_keystream_byte_cipher_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [arxkbc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [arxkbc_pkg::CsrDataWidth-1:0]  csr_data,
   arxkbc_req_if.sink                          req_if,
   arxkbc_rsp_if.source                        rsp_if
);
   import arxkbc_pkg::*;

   // config registers
   cipher_mode_type       mode_ff;
   logic [KeyWidth-1:0]   key_ff;

   // background seed warm-up
   mix_pair_type              seed_ff;
   mix_pair_type              seed_in;
   logic [WarmCountWidth-1:0] warm_count_ff;
   logic [WarmCountWidth-1:0] warm_count_in;
   logic                      seed_ready;

   // keystream state
   mix_pair_type mix_ff;
   mix_pair_type mix_in;
   logic         mid_buffer_ff;
   logic         mid_buffer_in;
   mix_pair_type mix_start;
   mix_pair_type mix_stepped;

   // response register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [DataWidth-1:0] data_out_ff;
   logic [DataWidth-1:0] data_out_in;
   logic                 mode_error_ff;
   logic                 mode_error_in;

   logic req_accept;
   logic key_write;

   assign key_write = csr_write && (csr_index_type'(csr_index) == CSR_KEY_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
         key_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_CIPHER_MODE: mode_ff <= cipher_mode_type'(csr_data[ModeWidth-1:0]);
            CSR_KEY_BITS:    key_ff  <= csr_data[KeyWidth-1:0];
            default: ;
         endcase
      end
   end

   // warm-up: load from the key, then one round per clock until the count runs out
   assign seed_ready = (warm_count_ff == '0);

   always_comb begin
      seed_in       = seed_ff;
      warm_count_in = warm_count_ff;
      priority if (key_write) begin
         seed_in       = seed_from_key(csr_data[KeyWidth-1:0]);
         warm_count_in = WarmCountWidth'(WarmRounds);
      end else if (!seed_ready) begin
         seed_in       = arx_round(seed_ff);
         warm_count_in = warm_count_ff - WarmCountWidth'(1);
      end else begin
         // seed warm, hold it
         seed_in       = seed_ff;
         warm_count_in = warm_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // key resets to zero, so warm up the zero-key seed
         seed_ff       <= seed_from_key('0);
         warm_count_ff <= WarmCountWidth'(WarmRounds);
      end else begin
         seed_ff       <= seed_in;
         warm_count_ff <= warm_count_in;
      end
   end

   // take a request when the seed is warm and the response slot frees up this cycle
   assign req_if.ready = seed_ready && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;

   // a buffer start swaps in the warmed seed before any step
   assign mix_start   = mid_buffer_ff ? mix_ff : seed_ff;
   assign mix_stepped = arx_round(mix_start);

   always_comb begin
      mix_in        = mix_start;
      data_out_in   = req_if.data_in;
      mode_error_in = 1'b0;
      unique case (mode_ff)
         MODE_NONE: ;
         MODE_SINGLE_XOR: begin
            data_out_in = req_if.data_in ^ key_ff[DataWidth-1:0];
         end
         MODE_ARX_STREAM: begin
            mix_in      = mix_stepped;
            data_out_in = req_if.data_in ^ mix_stepped.word_b[DataWidth-1:0];
         end
         MODE_UNSUPPORTED: begin
            mode_error_in = 1'b1;
         end
         default: ;
      endcase
      mid_buffer_in = !req_if.last_of_buffer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff        <= '0;
         mid_buffer_ff <= 1'b0;
      end else if (req_accept) begin
         mix_ff        <= mix_in;
         mid_buffer_ff <= mid_buffer_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         data_out_ff   <= data_out_in;
         mode_error_ff <= mode_error_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.data_out   = data_out_ff;
   assign rsp_if.mode_error = mode_error_ff;

endmodule
